// ===== rtl/core/psltrk_pkg.sv =====
// shared types, constants and helpers of the packet sequence loss tracker
`default_nettype none

package psltrk_pkg;

   localparam int unsigned NODES      = 2;
   localparam int unsigned NODE_IDX_W = 1;
   localparam int unsigned SEQ_W      = 32;
   localparam int unsigned CNT_W      = 32;
   localparam int unsigned VERDICT_W  = 3;
   localparam int unsigned CSR_IDX_W  = 8;

   // verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_FIRST    = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_IN_ORDER = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_GAP      = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_RESTART  = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_MISORDER = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_GAP         = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART_LOW_LIMIT = 8'd1;

   localparam logic [SEQ_W-1:0] RESET_GAP_DEFAULT         = 32'd1000;
   localparam logic [SEQ_W-1:0] RESTART_LOW_LIMIT_DEFAULT = 32'd100;

   typedef struct packed {
      logic             seen;
      logic [SEQ_W-1:0] last_seq;
      logic [CNT_W-1:0] packets;
      logic [CNT_W-1:0] drops;
      logic [CNT_W-1:0] misorders;
      logic [CNT_W-1:0] restarts;
   } node_entry_type;

   typedef struct packed {
      logic [SEQ_W-1:0] reset_gap;
      logic [SEQ_W-1:0] restart_low_limit;
   } cfg_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/psltrk_csr.sv =====
// configuration registers of the packet sequence loss tracker
`default_nettype none

module psltrk_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [psltrk_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [psltrk_pkg::SEQ_W-1:0]     csr_wdata,
   output psltrk_pkg::cfg_type                   cfg
);

   logic [psltrk_pkg::SEQ_W-1:0] reset_gap_ff;
   logic [psltrk_pkg::SEQ_W-1:0] restart_low_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_gap_ff         <= psltrk_pkg::RESET_GAP_DEFAULT;
         restart_low_limit_ff <= psltrk_pkg::RESTART_LOW_LIMIT_DEFAULT;
      end else if (csr_valid) begin
         case (csr_index)
            psltrk_pkg::CSR_RESET_GAP:         reset_gap_ff         <= csr_wdata;
            psltrk_pkg::CSR_RESTART_LOW_LIMIT: restart_low_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.reset_gap         = reset_gap_ff;
   assign cfg.restart_low_limit = restart_low_limit_ff;

endmodule

`default_nettype wire

// ===== rtl/core/psltrk_node_file.sv =====
// per-node tracking state with one read and one write port
`default_nettype none

module psltrk_node_file (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [psltrk_pkg::NODE_IDX_W-1:0] rd_idx,
   output psltrk_pkg::node_entry_type             rd_entry,
   input  wire logic                              wr_en,
   input  wire logic [psltrk_pkg::NODE_IDX_W-1:0] wr_idx,
   input  wire psltrk_pkg::node_entry_type        wr_entry
);

   psltrk_pkg::node_entry_type entry_ff [psltrk_pkg::NODES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < psltrk_pkg::NODES; i++) begin
            entry_ff[i] <= '0;
         end
      end else if (wr_en) begin
         entry_ff[wr_idx] <= wr_entry;
      end
   end

   assign rd_entry = entry_ff[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/core/psltrk_classify.sv =====
// classifies one packet against its node's state and builds the updated state
`default_nettype none

module psltrk_classify (
   input  wire psltrk_pkg::cfg_type               cfg,
   input  wire psltrk_pkg::node_entry_type        cur,
   input  wire logic                              seq_present,
   input  wire logic [psltrk_pkg::SEQ_W-1:0]      seq_number,
   output psltrk_pkg::node_entry_type             upd,
   output logic [psltrk_pkg::VERDICT_W-1:0]       verdict,
   output logic [psltrk_pkg::SEQ_W-1:0]           gap_size
);

   logic [psltrk_pkg::SEQ_W-1:0] next_seq;
   logic [psltrk_pkg::SEQ_W-1:0] seq;
   logic [psltrk_pkg::SEQ_W-1:0] gap;

   assign next_seq = cur.last_seq + 32'd1;
   assign seq      = seq_present ? seq_number : next_seq;
   assign gap      = seq - next_seq;

   always_comb begin
      upd          = cur;
      upd.last_seq = seq;
      gap_size     = '0;
      verdict      = psltrk_pkg::VERDICT_FIRST;
      if (!cur.seen) begin
         // first packet keeps the restart count
         upd.seen      = 1'b1;
         upd.packets   = 32'd1;
         upd.drops     = '0;
         upd.misorders = '0;
      end else begin
         if (seq == next_seq) begin
            verdict = psltrk_pkg::VERDICT_IN_ORDER;
         end else if (seq > next_seq) begin
            if (gap < cfg.reset_gap) begin
               gap_size  = gap;
               upd.drops = psltrk_pkg::sat_add(cur.drops, gap);
               verdict   = psltrk_pkg::VERDICT_GAP;
            end else begin
               upd.restarts = psltrk_pkg::sat_add(cur.restarts, 32'd1);
               verdict      = psltrk_pkg::VERDICT_RESTART;
            end
         end else if (cur.last_seq > cfg.reset_gap && seq < cfg.restart_low_limit) begin
            upd.restarts = psltrk_pkg::sat_add(cur.restarts, 32'd1);
            verdict      = psltrk_pkg::VERDICT_RESTART;
         end else begin
            upd.misorders = psltrk_pkg::sat_add(cur.misorders, 32'd1);
            verdict       = psltrk_pkg::VERDICT_MISORDER;
         end
         upd.packets = psltrk_pkg::sat_add(cur.packets, 32'd1);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/packet_sequence_loss_tracker_core.sv =====
// Packet sequence loss tracker, top level.
//
// req channel: one item per received packet. tuser carries node_index (bit 0)
// and seq_present (bit 1); tdata carries the 32-bit seq_number.
// rsp channel: one item per request. tuser carries the 3-bit verdict; tdata
// carries gap_size and the node's packet, drop, misorder and restart counts.
// csr channel: writes reset_gap (index 0) or restart_low_limit (index 1);
// always ready, other indexes are ignored. Write only while the block is idle.
//
// An accepted item is captured in the input register, is classified
// combinationally against its node's state, and lands in the result register
// when the output can advance; the node state is written at that same edge,
// so an item for the same node may follow directly. The block takes one item
// per cycle while the result register is empty or rsp_tready is high.
// When rsp_tready is low the result register holds and the input register
// keeps one more item; req_tready drops only when both are full.
// Reset clears all node state and loads reset_gap 1000, restart_low_limit 100.
`default_nettype none

module packet_sequence_loss_tracker_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [31:0]                      req_tdata,  // seq_number
   input  wire logic [1:0]                       req_tuser,  // node_index, seq_present
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // gap_size, packets_seen, drops_seen, misordered_seen, restarts_seen
   output logic [159:0]                          rsp_tdata,
   output logic [2:0]                            rsp_tuser,  // verdict
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [psltrk_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                      csr_wdata
);

   psltrk_pkg::cfg_type cfg;

   logic                                  in_valid_ff;
   logic [psltrk_pkg::NODE_IDX_W-1:0]     in_node_ff;
   logic                                  in_present_ff;
   logic [psltrk_pkg::SEQ_W-1:0]          in_seq_ff;

   logic                                  out_valid_ff;
   logic [psltrk_pkg::VERDICT_W-1:0]      out_verdict_ff;
   logic [psltrk_pkg::SEQ_W-1:0]          out_gap_ff;
   psltrk_pkg::node_entry_type            out_entry_ff;

   logic                                  advance;
   logic                                  fire;
   psltrk_pkg::node_entry_type            cur_entry;
   psltrk_pkg::node_entry_type            upd_entry;
   logic [psltrk_pkg::VERDICT_W-1:0]      verdict;
   logic [psltrk_pkg::SEQ_W-1:0]          gap_size;

   psltrk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_node_ff    <= req_tuser[0];
         in_present_ff <= req_tuser[1];
         in_seq_ff     <= req_tdata;
      end
   end

   psltrk_node_file u_node_file (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (in_node_ff),
      .rd_entry (cur_entry),
      .wr_en    (fire),
      .wr_idx   (in_node_ff),
      .wr_entry (upd_entry)
   );

   psltrk_classify u_classify (
      .cfg         (cfg),
      .cur         (cur_entry),
      .seq_present (in_present_ff),
      .seq_number  (in_seq_ff),
      .upd         (upd_entry),
      .verdict     (verdict),
      .gap_size    (gap_size)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_verdict_ff <= verdict;
         out_gap_ff     <= gap_size;
         out_entry_ff   <= upd_entry;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_verdict_ff;
   assign rsp_tdata  = {out_entry_ff.restarts, out_entry_ff.misorders,
                        out_entry_ff.drops, out_entry_ff.packets, out_gap_ff};

endmodule

`default_nettype wire
